// ===== design/plist_pkg.sv =====
// Shared constants and types for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Capacity);
  localparam int unsigned CountW    = AddrW + 1;

  localparam logic [CountW-1:0] CapCount = CountW'(Capacity);

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_GET    = 3'd2,
    REQ_SET    = 3'd3,
    REQ_FIND   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

endpackage

// ===== design/plist_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module plist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/positional_list_engine.sv =====
// Get reads the word and then reports; set, clear, append and failed requests report
// straight from the start state. Insert that moves entries and delete walk the entries
// from the end or from the position, and find walks from the front, with one memory read
// and at most one write per cycle. One request is worked on at a time, and the next is
// taken once the engine is back in idle after the result loads.
// Reset empties the list; the word memory is not cleared and needs no sweep.
`timescale 1ns / 1ps

module positional_list_engine import plist_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           req_type_i,
  input  logic [CountW-1:0]    position_i,
  input  logic [DataWidth-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ok_o,
  output logic [DataWidth-1:0] data_out_o,
  output logic [AddrW-1:0]     found_index_o,
  output logic [CountW-1:0]    length_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_START    = 7'b0000010,
    ST_SHIFT_UP = 7'b0000100,
    ST_SHIFT_DN = 7'b0001000,
    ST_SCAN     = 7'b0010000,
    ST_READ     = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  req_e                 kind_q;
  logic [CountW-1:0]    pos_q;
  logic [DataWidth-1:0] word_q;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [CountW-1:0]    ptr_q, ptr_d;
  logic [AddrW-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic                 first_q, first_d;
  logic                 ok_q, ok_d;
  logic [DataWidth-1:0] data_q, data_d;
  logic [AddrW-1:0]     found_q, found_d;

  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [DataWidth-1:0] out_data_q;
  logic [AddrW-1:0]     out_found_q;
  logic [CountW-1:0]    out_len_q;
  logic                 out_load;

  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [DataWidth-1:0] mem_wdata, mem_rdata;

  logic                 accept;
  logic [AddrW-1:0]     pos_a;
  logic [CountW-1:0]    ptr_dec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_a      = pos_q[AddrW-1:0];
  assign ptr_dec    = ptr_q - CountW'(1);

  plist_ram #(
    .Width (DataWidth),
    .Depth (Capacity)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    first_d   = first_q;
    ok_d      = ok_q;
    data_d    = data_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = pos_a;
    mem_wdata = word_q;
    mem_re    = 1'b0;
    mem_raddr = pos_a;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        ok_d    = 1'b0;
        data_d  = '0;
        found_d = '0;
        state_d = ST_DONE;
        case (kind_q)
          REQ_INSERT: begin
            if (pos_q <= cnt_q && cnt_q < CapCount) begin
              if (pos_q == cnt_q) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CountW'(1);
                ok_d   = 1'b1;
              end else begin
                ptr_d   = cnt_q;
                state_d = ST_SHIFT_UP;
              end
            end
          end
          REQ_DELETE: begin
            if (pos_q < cnt_q) begin
              ptr_d   = pos_q;
              first_d = 1'b1;
              state_d = ST_SHIFT_DN;
            end
          end
          REQ_GET: begin
            if (pos_q < cnt_q) begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
          end
          REQ_SET: begin
            if (pos_q < cnt_q) begin
              mem_we = 1'b1;
              ok_d   = 1'b1;
            end
          end
          REQ_FIND: begin
            if (word_q != '0) begin
              ptr_d   = '0;
              state_d = ST_SCAN;
            end
          end
          REQ_CLEAR: begin
            cnt_d = '0;
            ok_d  = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SHIFT_UP: begin
        // Entry k-1 is read, and written to entry k in the next cycle.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q + AddrW'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[AddrW-1:0];
          idx_d     = ptr_dec[AddrW-1:0];
          ptr_d     = ptr_dec;
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          mem_we  = 1'b1;
          cnt_d   = cnt_q + CountW'(1);
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SHIFT_DN: begin
        // The first read returns the removed word; later ones move down by one.
        if (pend_q) begin
          if (first_q) begin
            data_d  = mem_rdata;
            first_d = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_q - AddrW'(1);
            mem_wdata = mem_rdata;
          end
        end
        if (ptr_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AddrW-1:0];
          idx_d     = ptr_q[AddrW-1:0];
          ptr_d     = ptr_q + CountW'(1);
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CountW'(1);
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (pend_q && mem_rdata == word_q) begin
          ok_d    = 1'b1;
          found_d = idx_q;
          state_d = ST_DONE;
        end else if (ptr_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AddrW-1:0];
          idx_d     = ptr_q[AddrW-1:0];
          ptr_d     = ptr_q + CountW'(1);
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        data_d  = mem_rdata;
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_e'(req_type_i);
      pos_q  <= position_i;
      word_q <= value_i;
    end
    ptr_q   <= ptr_d;
    idx_q   <= idx_d;
    ok_q    <= ok_d;
    data_q  <= data_d;
    found_q <= found_d;
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_data_q  <= data_q;
      out_found_q <= found_q;
      out_len_q   <= cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign data_out_o    = out_data_q;
  assign found_index_o = out_found_q;
  assign length_o      = out_len_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCount)
    else $error("list length exceeds capacity");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("memory written while idle");

  a_rw_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same entry");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_index_o != '0 |-> ok_o)
    else $error("match index reported without success");

  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_START)
    else $error("accepted request not started");

endmodule

// ===== tb/positional_list_engine_test.sv =====
// Self-checking testbench for the positional list engine.
`timescale 1ns / 1ps

module positional_list_engine_test;
  import plist_pkg::*;

  // Request codes that the engine must answer as unknown.
  localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
  localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

  localparam int ITEMS_PER_PHASE = 190;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_GAP         = 30;
  localparam int SETTLE_CYCLES   = 80;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic                 ok;
    logic [DataWidth-1:0] data;
    logic [AddrW-1:0]     found;
    logic [CountW-1:0]    len;
  } list_reply_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [CountW-1:0]    pos;
    logic [DataWidth-1:0] word;
    logic                 typed_in;
    list_reply_t          want;
  } opening_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready_o;
  logic [2:0]           req_type;
  logic [CountW-1:0]    position;
  logic [DataWidth-1:0] value;
  logic                 out_valid_o;
  logic                 out_ready;
  logic                 ok_o;
  logic [DataWidth-1:0] data_out_o;
  logic [AddrW-1:0]     found_index_o;
  logic [CountW-1:0]    length_o;

  // Shadow copy of the list, advanced as each request is accepted.
  logic [DataWidth-1:0] shadow_words [Capacity];
  int                   shadow_len;

  list_reply_t pending_replies [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_asks;

  // Opening requests walk the list from empty through the boundary cases.
  opening_row_t opening_rows [25] = '{
    '{REQ_GET,        7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}},
    '{REQ_DELETE,     7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}},
    '{REQ_INSERT,     7'd1,   32'h0000_0005, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}},
    '{REQ_INSERT,     7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}},
    '{REQ_FIND,       7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}},
    '{REQ_INSERT,     7'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd0, 6'd0, 7'd1}},
    '{REQ_INSERT,     7'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'd0, 6'd0, 7'd2}},
    '{REQ_INSERT,     7'd2,   32'h8000_0001, 1'b1, '{1'b1, 32'd0, 6'd0, 7'd3}},
    '{REQ_INSERT,     7'd1,   32'h1234_5678, 1'b0, '0},
    '{REQ_GET,        7'd3,   32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0001, 6'd0, 7'd4}},
    '{REQ_GET,        7'd4,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd4}},
    '{REQ_FIND,       7'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_FIND,       7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd4}},
    '{REQ_FIND,       7'd0,   32'hDEAD_BEEF, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd4}},
    '{REQ_SET,        7'd0,   32'hA5A5_A5A5, 1'b1, '{1'b1, 32'd0, 6'd0, 7'd4}},
    '{REQ_SET,        7'd4,   32'h0000_0001, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd4}},
    '{REQ_SET,        7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd4}},
    '{REQ_DELETE,     7'd1,   32'h0000_0000, 1'b0, '0},
    '{REQ_DELETE,     7'd127, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd3}},
    '{REQ_RESERVED_6, 7'd0,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd3}},
    '{REQ_RESERVED_7, 7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd3}},
    '{REQ_FIND,       7'd0,   32'h8000_0001, 1'b0, '0},
    '{REQ_DELETE,     7'd0,   32'h0000_0000, 1'b0, '0},
    '{REQ_CLEAR,      7'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'd0, 6'd0, 7'd0}},
    '{REQ_GET,        7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 6'd0, 7'd0}}
  };

  positional_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type),
    .position_i    (position),
    .value_i       (value),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .ok_o          (ok_o),
    .data_out_o    (data_out_o),
    .found_index_o (found_index_o),
    .length_o      (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("positional_list_engine test failed");
    $finish;
  end

  function automatic list_reply_t predict_list_reply(logic [2:0] kind,
                                                     logic [CountW-1:0] pos,
                                                     logic [DataWidth-1:0] word);
    list_reply_t reply;
    int at;
    reply = '0;
    at = int'(pos);
    case (kind)
      REQ_INSERT: begin
        if (at <= shadow_len && shadow_len < int'(Capacity)) begin
          for (int k = shadow_len; k > at; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[at] = word;
          shadow_len++;
          reply.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (at < shadow_len) begin
          reply.data = shadow_words[at];
          for (int k = at; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
          shadow_len--;
          reply.ok = 1'b1;
        end
      end
      REQ_GET: begin
        if (at < shadow_len) begin
          reply.data = shadow_words[at];
          reply.ok = 1'b1;
        end
      end
      REQ_SET: begin
        if (at < shadow_len) begin
          shadow_words[at] = word;
          reply.ok = 1'b1;
        end
      end
      REQ_FIND: begin
        // Walking downwards leaves the lowest matching index behind.
        if (word != '0) begin
          for (int k = shadow_len - 1; k >= 0; k--) begin
            if (shadow_words[k] == word) begin
              reply.ok = 1'b1;
              reply.found = AddrW'(k);
            end
          end
        end
      end
      REQ_CLEAR: begin
        shadow_len = 0;
        reply.ok = 1'b1;
      end
      default: ;
    endcase
    reply.len = CountW'(shadow_len);
    return reply;
  endfunction

  // Offers one request and records its reply once the engine has taken it.
  task automatic offer_request(input logic [2:0] kind, input logic [CountW-1:0] pos,
                               input logic [DataWidth-1:0] word, input logic typed_in,
                               input list_reply_t typed_reply);
    int gap;
    list_reply_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= word;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    predicted = predict_list_reply(kind, pos, word);
    pending_replies.push_back(typed_in ? typed_reply : predicted);
  endtask

  task automatic offer_predicted(input logic [2:0] kind, input logic [CountW-1:0] pos,
                                 input logic [DataWidth-1:0] word);
    offer_request(kind, pos, word, 1'b0, '0);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataWidth-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return DataWidth'($urandom_range(1, 8));
      default: return DataWidth'($urandom);
    endcase
  endfunction

  // Draws a request from the current list contents; grow_pct sets how often it inserts.
  task automatic draw_request(input int grow_pct, output logic [2:0] kind,
                              output logic [CountW-1:0] pos, output logic [DataWidth-1:0] word);
    int top;
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) kind = $urandom_range(1) ? REQ_RESERVED_7 : REQ_RESERVED_6;
    else if (pick < 4) kind = REQ_CLEAR;
    else if ($urandom_range(99) < grow_pct) kind = REQ_INSERT;
    else begin
      case ($urandom_range(3))
        0:       kind = REQ_DELETE;
        1:       kind = REQ_GET;
        2:       kind = REQ_SET;
        default: kind = REQ_FIND;
      endcase
    end
    word = random_word();
    if (kind == REQ_FIND && shadow_len > 0 && $urandom_range(9) < 6)
      word = shadow_words[$urandom_range(shadow_len - 1)];
    top = (kind == REQ_INSERT) ? shadow_len : shadow_len - 1;
    if (top >= 0 && $urandom_range(9) < 8) pos = CountW'($urandom_range(top));
    else pos = CountW'($urandom_range(127));
  endtask

  // Fills the list to capacity, then pushes against the full list.
  task automatic fill_list();
    while (shadow_len < int'(Capacity))
      offer_predicted(REQ_INSERT, CountW'($urandom_range(shadow_len)), random_word());
    offer_predicted(REQ_INSERT, CountW'(Capacity), DataWidth'($urandom));
    offer_predicted(REQ_INSERT, '0, DataWidth'($urandom));
    offer_predicted(REQ_FIND, '0, shadow_words[Capacity-1]);
    offer_predicted(REQ_GET, CountW'(Capacity - 1), '0);
    offer_predicted(REQ_SET, CountW'(Capacity - 1), DataWidth'($urandom));
    offer_predicted(REQ_DELETE, CountW'(Capacity - 1), '0);
    offer_predicted(REQ_INSERT, CountW'(Capacity - 1), DataWidth'($urandom));
  endtask

  function automatic void note_failure(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", what);
  endfunction

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
  initial begin
    int asks_served;
    int held;
    asks_served = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_asks != asks_served) begin
        asks_served = hold_off_asks;
        held = HOLD_OFF_CYCLES;
      end
      if (held > 0) begin
        out_ready <= 1'b0;
        held--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Replies are checked at the falling edge before the rising edge that takes them.
  initial begin
    list_reply_t want;
    list_reply_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready === 1'b1) begin
        got = '{ok_o, data_out_o, found_index_o, length_o};
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("reply with no request outstanding: ok %0b data %h idx %0d len %0d",
                                 got.ok, got.data, got.found, got.len));
        end else begin
          want = pending_replies.pop_front();
          if (got.ok !== want.ok || got.data !== want.data || got.found !== want.found ||
              got.len !== want.len) begin
            note_failure($sformatf(
              "reply mismatch: expected ok %0b data %h idx %0d len %0d, got ok %0b data %h idx %0d len %0d",
              want.ok, want.data, want.found, want.len, got.ok, got.data, got.found, got.len));
          end
        end
      end
    end
  end

  initial begin
    logic [2:0]           kind;
    logic [CountW-1:0]    pos;
    logic [DataWidth-1:0] word;
    int                   grow_pct;
    mismatch_count = 0;
    hold_off_asks  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    shadow_len     = 0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    req_type <= REQ_GET;
    position <= '0;
    value    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i])
      offer_request(opening_rows[i].kind, opening_rows[i].pos, opening_rows[i].word,
                    opening_rows[i].typed_in, opening_rows[i].want);
    wait_for_replies();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (phase == 0 || phase == 3) fill_list();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Alternate stretches that grow and shrink the list.
        grow_pct = ((n / 35) % 2 == 0) ? 60 : 15;
        if (phase == 0 && n == 60) hold_off_asks++;
        draw_request(grow_pct, kind, pos, word);
        offer_predicted(kind, pos, word);
      end
      wait_for_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/plist_pkg.sv
design/plist_ram.sv
design/positional_list_engine.sv
tb/positional_list_engine_test.sv
